FILE: hdl/p256chk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p256chk_pkg
// Shared types, curve constants and the microcode table of the secp256r1
// point-on-curve check.
// ----------------------------------------------------------------------------
package p256chk_pkg;

  localparam int unsigned NumW   = 256;
  localparam int unsigned PcW    = 4;
  localparam int unsigned CntW   = 8;

  // secp256r1 field prime and curve coefficients
  localparam logic [NumW-1:0] PrimeP =
    256'hFFFFFFFF00000001_0000000000000000_00000000FFFFFFFF_FFFFFFFFFFFFFFFF;
  localparam logic [NumW-1:0] CoefA =
    256'hFFFFFFFF00000001_0000000000000000_00000000FFFFFFFF_FFFFFFFFFFFFFFFC;
  localparam logic [NumW-1:0] CoefB =
    256'h5AC635D8AA3A93E7_B3EBBD55769886BC_651D06B0CC53B0F6_3BCE3C3E27D2604B;

  typedef logic [PcW-1:0] pc_t;

  // result codes
  typedef enum logic [1:0] {
    ST_ON_CURVE = 2'd0,
    ST_RANGE    = 2'd1,
    ST_EQ_FAIL  = 2'd2
  } status_e;

  // accumulator update
  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_ZERO,
    ACC_SUM,
    ACC_SUM_IF_BIT
  } acc_sel_e;

  // second operand of the modular adder
  typedef enum logic [1:0] {
    OPND_ACC,
    OPND_U,
    OPND_A,
    OPND_B
  } opnd_sel_e;

  // multiplicand / multiplier load
  typedef enum logic [1:0] {
    LD_NONE,
    LD_Y,
    LD_X,
    LD_ACC_X
  } load_sel_e;

  // sequencing
  typedef enum logic [2:0] {
    J_NEXT,
    J_RANGE,
    J_LOOP,
    J_CMP,
    J_FIN
  } jump_e;

  typedef struct packed {
    acc_sel_e  acc;
    opnd_sel_e opnd;
    load_sel_e load;
    logic      lhs_we;
    logic      bit_step;
    jump_e     jmp;
    pc_t       target;
  } ctl_t;

  localparam pc_t PcFin = pc_t'(13);

  // control word for one program step
  function automatic ctl_t ctl_rom(input pc_t pc);
    ctl_t c;
    c = '{acc: ACC_HOLD, opnd: OPND_ACC, load: LD_NONE, lhs_we: 1'b0,
          bit_step: 1'b0, jmp: J_NEXT, target: '0};
    case (pc)
      // range check of both coordinates
      pc_t'(0): begin
        c.jmp = J_RANGE;
        c.target = PcFin;
      end
      // y * y
      pc_t'(1): begin
        c.load = LD_Y;
        c.acc = ACC_ZERO;
      end
      pc_t'(2): begin
        c.acc = ACC_SUM;
        c.opnd = OPND_ACC;
      end
      pc_t'(3): begin
        c.acc = ACC_SUM_IF_BIT;
        c.opnd = OPND_U;
        c.bit_step = 1'b1;
        c.jmp = J_LOOP;
        c.target = pc_t'(2);
      end
      // keep lhs, then x * x
      pc_t'(4): begin
        c.lhs_we = 1'b1;
        c.load = LD_X;
        c.acc = ACC_ZERO;
      end
      pc_t'(5): begin
        c.acc = ACC_SUM;
        c.opnd = OPND_ACC;
      end
      pc_t'(6): begin
        c.acc = ACC_SUM_IF_BIT;
        c.opnd = OPND_U;
        c.bit_step = 1'b1;
        c.jmp = J_LOOP;
        c.target = pc_t'(5);
      end
      // x^2 + a
      pc_t'(7): begin
        c.acc = ACC_SUM;
        c.opnd = OPND_A;
      end
      // (x^2 + a) * x
      pc_t'(8): begin
        c.load = LD_ACC_X;
        c.acc = ACC_ZERO;
      end
      pc_t'(9): begin
        c.acc = ACC_SUM;
        c.opnd = OPND_ACC;
      end
      pc_t'(10): begin
        c.acc = ACC_SUM_IF_BIT;
        c.opnd = OPND_U;
        c.bit_step = 1'b1;
        c.jmp = J_LOOP;
        c.target = pc_t'(9);
      end
      // + b
      pc_t'(11): begin
        c.acc = ACC_SUM;
        c.opnd = OPND_B;
      end
      pc_t'(12): begin
        c.jmp = J_CMP;
      end
      default: begin
        c.jmp = J_FIN;
      end
    endcase
    return c;
  endfunction

endpackage

FILE: hdl/p256chk_key_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p256chk_key_if
// Input channel: one uncompressed public key, most significant word first.
// ----------------------------------------------------------------------------
interface p256chk_key_if;
  logic        valid;
  logic        ready;
  logic [63:0] x_word_3;
  logic [63:0] x_word_2;
  logic [63:0] x_word_1;
  logic [63:0] x_word_0;
  logic [63:0] y_word_3;
  logic [63:0] y_word_2;
  logic [63:0] y_word_1;
  logic [63:0] y_word_0;

  modport source (
    output valid, x_word_3, x_word_2, x_word_1, x_word_0,
           y_word_3, y_word_2, y_word_1, y_word_0,
    input  ready
  );
  modport sink (
    input  valid, x_word_3, x_word_2, x_word_1, x_word_0,
           y_word_3, y_word_2, y_word_1, y_word_0,
    output ready
  );
endinterface

FILE: hdl/p256chk_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p256chk_res_if
// Output channel: pass flag and status code of one key check.
// ----------------------------------------------------------------------------
interface p256chk_res_if;
  logic       valid;
  logic       ready;
  logic       point_valid;
  logic [1:0] check_status;

  modport source (
    output valid, point_valid, check_status,
    input  ready
  );
  modport sink (
    input  valid, point_valid, check_status,
    output ready
  );
endinterface

FILE: hdl/p256chk_addmod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p256chk_addmod
// Modular adder: (a + b) mod p for a, b below p, one conditional subtract.
// ----------------------------------------------------------------------------
module p256chk_addmod
  import p256chk_pkg::*;
(
  input  logic [NumW-1:0] a_i,
  input  logic [NumW-1:0] b_i,
  output logic [NumW-1:0] sum_o
);

  logic [NumW:0]   sum;
  logic [NumW+1:0] diff;

  // raw sum and trial subtraction of p
  assign sum  = {1'b0, a_i} + {1'b0, b_i};
  assign diff = {1'b0, sum} - {2'b00, PrimeP};

  // keep the reduced value unless the subtraction borrowed
  assign sum_o = diff[NumW+1] ? sum[NumW-1:0] : diff[NumW-1:0];

endmodule

FILE: hdl/p256_point_on_curve_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p256_point_on_curve_check
// Checks that a secp256r1 public key (X, Y) is a point on the curve.
// ----------------------------------------------------------------------------
// Usage:
//   key_i carries X and Y as four 64-bit words each, most significant first.
//   A key is taken when valid and ready are both high; ready is high only
//   while no key is being worked on.
//   res_o returns one word per key: point_valid and check_status
//   (on curve, coordinate not below p, equation fails).
// Sequence:
//   a key with a coordinate not below p goes from the range step straight
//   to the final step. Otherwise a microcoded program runs three modular
//   products, each 256 double-and-add iterations (a doubling step, then a
//   conditional add) on the single 256-bit modular adder, plus setup steps.
//   One key is handled at a time; the next key waits for the result load.
// Reset:
//   clears the program counter, the busy flag and the output valid flag.
// Stall:
//   a finished result sits in the output register; if the receiver holds
//   ready low the program waits in its last step, and no new key is taken.
// ----------------------------------------------------------------------------
module p256_point_on_curve_check
  import p256chk_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  p256chk_key_if.sink   key_i,
  p256chk_res_if.source res_o
);

  // sequencer state
  logic            busy_q, busy_d;
  pc_t             pc_q, pc_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  status_e         st_q, st_d;

  // datapath registers
  logic [NumW-1:0] x_q, y_q, u_q, m_q, acc_q, lhs_q;

  // output register
  logic            out_valid_q, out_valid_d;
  logic            out_pass_q;
  status_e         out_st_q;

  ctl_t            ctl;
  logic [NumW-1:0] opnd_b;
  logic [NumW-1:0] sum;
  logic            key_acc;
  logic            out_free;
  logic            out_load;
  logic            range_bad;

  assign key_acc  = key_i.valid && key_i.ready;
  assign out_free = !out_valid_q || res_o.ready;
  assign ctl      = ctl_rom(pc_q);

  assign key_i.ready       = !busy_q;
  assign res_o.valid       = out_valid_q;
  assign res_o.point_valid = out_pass_q;
  assign res_o.check_status = out_st_q;

  // adder operand select
  always_comb begin
    case (ctl.opnd)
      OPND_ACC: opnd_b = acc_q;
      OPND_U:   opnd_b = u_q;
      OPND_A:   opnd_b = CoefA;
      OPND_B:   opnd_b = CoefB;
      default:  opnd_b = acc_q;
    endcase
  end

  p256chk_addmod u_addmod (
    .a_i   (acc_q),
    .b_i   (opnd_b),
    .sum_o (sum)
  );

  assign range_bad = (x_q >= PrimeP) || (y_q >= PrimeP);

  // program sequencing
  always_comb begin
    busy_d      = busy_q;
    pc_d        = pc_q + pc_t'(1);
    cnt_d       = cnt_q;
    st_d        = st_q;
    out_load    = 1'b0;
    out_valid_d = out_valid_q;

    if (out_valid_q && res_o.ready) begin
      out_valid_d = 1'b0;
    end

    if (ctl.bit_step) begin
      cnt_d = cnt_q - CntW'(1);
    end
    if (ctl.load != LD_NONE) begin
      cnt_d = CntW'(NumW - 1);
    end

    if (!busy_q) begin
      pc_d = '0;
      if (key_acc) begin
        busy_d = 1'b1;
        st_d   = ST_ON_CURVE;
      end
    end else begin
      case (ctl.jmp)
        J_NEXT: begin
        end
        J_RANGE: begin
          if (range_bad) begin
            st_d = ST_RANGE;
            pc_d = ctl.target;
          end
        end
        J_LOOP: begin
          if (cnt_q != '0) begin
            pc_d = ctl.target;
          end
        end
        J_CMP: begin
          st_d = (acc_q == lhs_q) ? ST_ON_CURVE : ST_EQ_FAIL;
        end
        J_FIN: begin
          pc_d = pc_q;
          if (out_free) begin
            out_load    = 1'b1;
            out_valid_d = 1'b1;
            busy_d      = 1'b0;
            pc_d        = '0;
          end
        end
        default: begin
          pc_d = pc_q;
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    st_q  <= st_d;

    if (key_acc) begin
      x_q <= {key_i.x_word_3, key_i.x_word_2, key_i.x_word_1, key_i.x_word_0};
      y_q <= {key_i.y_word_3, key_i.y_word_2, key_i.y_word_1, key_i.y_word_0};
    end

    if (busy_q) begin
      // accumulator
      case (ctl.acc)
        ACC_HOLD:       acc_q <= acc_q;
        ACC_ZERO:       acc_q <= '0;
        ACC_SUM:        acc_q <= sum;
        ACC_SUM_IF_BIT: acc_q <= m_q[NumW-1] ? sum : acc_q;
        default:        acc_q <= acc_q;
      endcase

      // multiplicand and multiplier
      case (ctl.load)
        LD_NONE: begin
          if (ctl.bit_step) begin
            m_q <= {m_q[NumW-2:0], 1'b0};
          end
        end
        LD_Y: begin
          u_q <= y_q;
          m_q <= y_q;
        end
        LD_X: begin
          u_q <= x_q;
          m_q <= x_q;
        end
        LD_ACC_X: begin
          u_q <= acc_q;
          m_q <= x_q;
        end
        default: begin
        end
      endcase

      if (ctl.lhs_we) begin
        lhs_q <= acc_q;
      end
    end

    // result word
    if (out_load) begin
      out_pass_q <= (st_q == ST_ON_CURVE);
      out_st_q   <= st_q;
    end
  end

endmodule
